/* src/plef_pkg.sv */
// ----------------------------------------------------------------------------
// plef_pkg: shared types and constants for the polygon longest edge finder
// Coordinate and length widths, the short-edge ratio, the count limit and
// the configuration register indexes.
// ----------------------------------------------------------------------------
package plef_pkg;

   localparam int COORD_W      = 12;
   localparam int MAX_VERTICES = 1024;
   localparam int COUNT_FIELD_MAX = 2047;
   localparam int COUNT_LIMIT  = (MAX_VERTICES < COUNT_FIELD_MAX) ? MAX_VERTICES
                                                                 : COUNT_FIELD_MAX;
   localparam int COUNT_W      = 11;

   // squared length of an edge: dx^2 + dy^2 needs one bit above a square
   localparam int SQ_W  = 2 * COORD_W;
   localparam int LEN_W = SQ_W + 1;

   // short edge: len <= 0.8 * excl, exact as 25*len^2 <= 16*excl^2
   localparam int SHORT_NUM = 25;
   localparam int SHORT_DEN = 16;
   localparam int CMP_W     = LEN_W + 5;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = COORD_W;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EXCL_ENABLE = 3'd0,
      CSR_EXCL_HEAD_X = 3'd1,
      CSR_EXCL_HEAD_Y = 3'd2,
      CSR_EXCL_TAIL_X = 3'd3,
      CSR_EXCL_TAIL_Y = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] x;
   } point_type;

   typedef struct packed {
      point_type head;
      point_type tail;
   } edge_type;

endpackage

/* src/plef_sq_len.sv */
// ----------------------------------------------------------------------------
// plef_sq_len: exact squared length of one edge
// Absolute coordinate differences, two narrow squares and their sum.
// ----------------------------------------------------------------------------
module plef_sq_len (
   input  plef_pkg::edge_type              edge_in,
   output logic [plef_pkg::LEN_W-1:0]      len_sq
);

   logic [plef_pkg::COORD_W-1:0] dx;
   logic [plef_pkg::COORD_W-1:0] dy;
   logic [plef_pkg::SQ_W-1:0]    dx_sq;
   logic [plef_pkg::SQ_W-1:0]    dy_sq;

   always_comb begin
      dx = (edge_in.head.x > edge_in.tail.x) ? edge_in.head.x - edge_in.tail.x
                                             : edge_in.tail.x - edge_in.head.x;
      dy = (edge_in.head.y > edge_in.tail.y) ? edge_in.head.y - edge_in.tail.y
                                             : edge_in.tail.y - edge_in.head.y;
      dx_sq = plef_pkg::SQ_W'(dx) * plef_pkg::SQ_W'(dx);
      dy_sq = plef_pkg::SQ_W'(dy) * plef_pkg::SQ_W'(dy);
      len_sq = plef_pkg::LEN_W'(dx_sq) + plef_pkg::LEN_W'(dy_sq);
   end

endmodule

/* src/polygon_longest_edge_finder.sv */
// ----------------------------------------------------------------------------
// polygon_longest_edge_finder: longest non-excluded edge of a closed polygon
// Vertices stream in one word each; the last one closes the polygon and
// yields one result word with the longest edge and the short-edge count.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+---------------------------------------
//  req     | in  | req_tvalid/req_tready | tdata: vertex_x, vertex_y; tlast: final
//  rsp     | out | rsp_tvalid/rsp_tready | tdata: edge ends, count; tuser: found
//  csr     | in  | csr_we                | csr_index, csr_wdata
//
//  One vertex per cycle while req_tready is high. After its last vertex is
//  accepted, a result passes edge capture and squared lengths, then the
//  running maximum and count update straight into the output register.
//  The output register has a one-word skid stage behind it; req_tready drops
//  only while that skid word is held, and then the whole pipeline holds.
//  Synchronous reset clears pipeline valids, polygon state and registers.
//  Write the csr registers only while no vertex is in flight.
//
module polygon_longest_edge_finder (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata, low bit up: vertex_x[11:0], vertex_y[23:12]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [plef_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                               req_tlast,
   // rsp_tdata, low bit up: long_tail_x, long_tail_y, long_head_x,
   // long_head_y, shorter_count[58:48], zero pad
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [plef_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // rsp_tuser: found
   output logic                               rsp_tuser,
   input  logic                               csr_we,
   input  logic [plef_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [plef_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // ------------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------------
   logic                  excl_en_ff;
   plef_pkg::edge_type    excl_edge_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         excl_en_ff   <= 1'b0;
         excl_edge_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            plef_pkg::CSR_EXCL_ENABLE: excl_en_ff          <= csr_wdata[0];
            plef_pkg::CSR_EXCL_HEAD_X: excl_edge_ff.head.x <= csr_wdata;
            plef_pkg::CSR_EXCL_HEAD_Y: excl_edge_ff.head.y <= csr_wdata;
            plef_pkg::CSR_EXCL_TAIL_X: excl_edge_ff.tail.x <= csr_wdata;
            plef_pkg::CSR_EXCL_TAIL_Y: excl_edge_ff.tail.y <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // flow control: the whole pipeline advances unless the skid word is held
   // ------------------------------------------------------------------------
   logic skid_valid_ff;
   logic advance;
   logic accept;

   assign advance    = !skid_valid_ff;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;

   // ------------------------------------------------------------------------
   // stage 1: form the open edge and the closing edge of this vertex
   // ------------------------------------------------------------------------
   plef_pkg::point_type cur_pt;
   plef_pkg::point_type prev_pt_ff;
   plef_pkg::point_type first_pt_ff;
   logic                have_first_ff;

   plef_pkg::edge_type  e1_in;
   plef_pkg::edge_type  e2_in;
   logic                e1_skip;
   logic                e2_skip;
   logic [plef_pkg::LEN_W-1:0] excl_len;

   assign cur_pt.x = req_tdata[plef_pkg::COORD_W-1:0];
   assign cur_pt.y = req_tdata[2*plef_pkg::COORD_W-1:plef_pkg::COORD_W];

   always_comb begin
      e1_in.tail = prev_pt_ff;
      e1_in.head = cur_pt;
      e2_in.tail = cur_pt;
      e2_in.head = have_first_ff ? first_pt_ff : cur_pt;
      // excluded edge matches in either direction
      e1_skip = excl_en_ff && ((e1_in == excl_edge_ff) ||
                               (e1_in.tail == excl_edge_ff.head &&
                                e1_in.head == excl_edge_ff.tail));
      e2_skip = excl_en_ff && ((e2_in == excl_edge_ff) ||
                               (e2_in.tail == excl_edge_ff.head &&
                                e2_in.head == excl_edge_ff.tail));
   end

   plef_sq_len u_excl_len (
      .edge_in (excl_edge_ff),
      .len_sq  (excl_len)
   );

   // track first and previous vertex; a last vertex ends the polygon
   always_ff @(posedge clock) begin
      if (reset) begin
         have_first_ff <= 1'b0;
      end else if (accept) begin
         have_first_ff <= !req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prev_pt_ff <= cur_pt;
         if (!have_first_ff) begin
            first_pt_ff <= cur_pt;
         end
      end
   end

   logic                       s1_valid_ff;
   logic                       s1_last_ff;
   plef_pkg::edge_type         s1_e1_ff;
   plef_pkg::edge_type         s1_e2_ff;
   logic                       s1_e1_use_ff;
   logic                       s1_e2_use_ff;
   logic                       s1_excl_en_ff;
   logic [plef_pkg::LEN_W-1:0] s1_excl_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_last_ff     <= req_tlast;
         s1_e1_ff       <= e1_in;
         s1_e2_ff       <= e2_in;
         s1_e1_use_ff   <= have_first_ff && !e1_skip;
         s1_e2_use_ff   <= req_tlast && !e2_skip;
         s1_excl_en_ff  <= excl_en_ff;
         s1_excl_len_ff <= excl_len;
      end
   end

   // ------------------------------------------------------------------------
   // stage 2: squared lengths of both edges
   // ------------------------------------------------------------------------
   logic [plef_pkg::LEN_W-1:0] len1_in;
   logic [plef_pkg::LEN_W-1:0] len2_in;

   plef_sq_len u_len1 (
      .edge_in (s1_e1_ff),
      .len_sq  (len1_in)
   );

   plef_sq_len u_len2 (
      .edge_in (s1_e2_ff),
      .len_sq  (len2_in)
   );

   logic                       s2_valid_ff;
   logic                       s2_last_ff;
   plef_pkg::edge_type         s2_e1_ff;
   plef_pkg::edge_type         s2_e2_ff;
   logic                       s2_e1_use_ff;
   logic                       s2_e2_use_ff;
   logic                       s2_excl_en_ff;
   logic [plef_pkg::LEN_W-1:0] s2_excl_len_ff;
   logic [plef_pkg::LEN_W-1:0] s2_len1_ff;
   logic [plef_pkg::LEN_W-1:0] s2_len2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_last_ff     <= s1_last_ff;
         s2_e1_ff       <= s1_e1_ff;
         s2_e2_ff       <= s1_e2_ff;
         s2_e1_use_ff   <= s1_e1_use_ff;
         s2_e2_use_ff   <= s1_e2_use_ff;
         s2_excl_en_ff  <= s1_excl_en_ff;
         s2_excl_len_ff <= s1_excl_len_ff;
         s2_len1_ff     <= len1_in;
         s2_len2_ff     <= len2_in;
      end
   end

   // ------------------------------------------------------------------------
   // stage 3: running maximum and short-edge count, open edge first
   // ------------------------------------------------------------------------
   logic [plef_pkg::LEN_W-1:0]   best_len_ff,   best_len_in;
   plef_pkg::edge_type           best_edge_ff,  best_edge_in;
   logic                         best_valid_ff, best_valid_in;
   logic [plef_pkg::COUNT_W-1:0] short_cnt_ff,  short_cnt_in;

   logic                         take1;
   logic                         take2;
   logic [plef_pkg::LEN_W-1:0]   mid_len;
   plef_pkg::edge_type           mid_edge;
   logic                         mid_valid;
   logic [plef_pkg::CMP_W-1:0]   excl_scaled;
   logic                         short1;
   logic                         short2;
   logic [plef_pkg::COUNT_W-1:0] mid_cnt;
   logic                         res_push;

   always_comb begin
      take1     = s2_e1_use_ff && (s2_len1_ff > best_len_ff);
      mid_len   = take1 ? s2_len1_ff : best_len_ff;
      mid_edge  = take1 ? s2_e1_ff   : best_edge_ff;
      mid_valid = take1 || best_valid_ff;
      take2     = s2_e2_use_ff && (s2_len2_ff > mid_len);
      best_len_in   = take2 ? s2_len2_ff : mid_len;
      best_edge_in  = take2 ? s2_e2_ff   : mid_edge;
      best_valid_in = take2 || mid_valid;

      excl_scaled = plef_pkg::CMP_W'(s2_excl_len_ff) *
                    plef_pkg::CMP_W'(plef_pkg::SHORT_DEN);
      short1 = !s2_excl_en_ff ||
               ((s2_excl_len_ff != '0) &&
                (plef_pkg::CMP_W'(s2_len1_ff) * plef_pkg::CMP_W'(plef_pkg::SHORT_NUM)
                 <= excl_scaled));
      short2 = !s2_excl_en_ff ||
               ((s2_excl_len_ff != '0) &&
                (plef_pkg::CMP_W'(s2_len2_ff) * plef_pkg::CMP_W'(plef_pkg::SHORT_NUM)
                 <= excl_scaled));

      // saturate at the count limit
      mid_cnt = (s2_e1_use_ff && short1 &&
                 short_cnt_ff < plef_pkg::COUNT_W'(plef_pkg::COUNT_LIMIT))
                ? short_cnt_ff + 1'b1 : short_cnt_ff;
      short_cnt_in = (s2_e2_use_ff && short2 &&
                      mid_cnt < plef_pkg::COUNT_W'(plef_pkg::COUNT_LIMIT))
                     ? mid_cnt + 1'b1 : mid_cnt;

      res_push = advance && s2_valid_ff && s2_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_len_ff   <= '0;
         best_valid_ff <= 1'b0;
         short_cnt_ff  <= '0;
      end else if (advance && s2_valid_ff) begin
         if (s2_last_ff) begin
            // polygon closed: drop all running state
            best_len_ff   <= '0;
            best_valid_ff <= 1'b0;
            short_cnt_ff  <= '0;
         end else begin
            best_len_ff   <= best_len_in;
            best_valid_ff <= best_valid_in;
            short_cnt_ff  <= short_cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s2_valid_ff) begin
         best_edge_ff <= best_edge_in;
      end
   end

   // ------------------------------------------------------------------------
   // result word and skid stage
   // ------------------------------------------------------------------------
   logic [plef_pkg::RSP_DATA_W-1:0] res_data;
   logic                            res_found;
   plef_pkg::edge_type              res_edge;

   always_comb begin
      res_found = best_valid_in;
      res_edge  = best_valid_in ? best_edge_in : '0;
      res_data  = plef_pkg::RSP_DATA_W'({short_cnt_in,
                                         res_edge.head.y, res_edge.head.x,
                                         res_edge.tail.y, res_edge.tail.x});
   end

   logic                            rsp_valid_ff;
   logic [plef_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic                            rsp_found_ff;
   logic [plef_pkg::RSP_DATA_W-1:0] skid_data_ff;
   logic                            skid_found_ff;
   logic                            main_free;

   assign main_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (main_free) begin
            rsp_valid_ff <= skid_valid_ff || res_push;
         end
         if (skid_valid_ff) begin
            if (rsp_tready) begin
               skid_valid_ff <= 1'b0;
            end
         end else begin
            skid_valid_ff <= res_push && !main_free;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (main_free) begin
         rsp_data_ff  <= skid_valid_ff ? skid_data_ff  : res_data;
         rsp_found_ff <= skid_valid_ff ? skid_found_ff : res_found;
      end
      if (res_push && !main_free) begin
         skid_data_ff  <= res_data;
         skid_found_ff <= res_found;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_found_ff;

`ifndef SYNTHESIS
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid word held with empty output register");

   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && !rsp_tready))
      else $error("skid word filled while output register was free");

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      short_cnt_ff <= plef_pkg::COUNT_W'(plef_pkg::COUNT_LIMIT))
      else $error("short edge count above limit");

   a_best_zero_when_none: assert property (@(posedge clock) disable iff (reset)
      !best_valid_ff |-> (best_len_ff == '0))
      else $error("best length nonzero with no edge kept");

   a_clear_after_result: assert property (@(posedge clock) disable iff (reset)
      res_push |=> (!best_valid_ff && short_cnt_ff == '0 && rsp_valid_ff))
      else $error("polygon state not cleared after result");
`endif

endmodule

/* verif/polygon_longest_edge_finder_test.sv */
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// polygon_longest_edge_finder_test: self-checking bench for the edge finder
// Streams closed polygons into the block and keeps its own running model of
// the longest kept edge and the short-edge count. Each result word is checked
// field by field against that model. Runs go through several exclusion
// settings and idle/stall mixes, one long output hold-off and one polygon
// long enough to saturate the count.
// ----------------------------------------------------------------------------
module polygon_longest_edge_finder_test;

   typedef logic [plef_pkg::COORD_W-1:0] coord_type;

   // one polygon result as the block should report it
   typedef struct {
      logic                         found;
      coord_type                    tail_x;
      coord_type                    tail_y;
      coord_type                    head_x;
      coord_type                    head_y;
      logic [plef_pkg::COUNT_W-1:0] count;
   } edge_report_type;

   // exclusion setups the random part cycles through
   typedef enum int {
      EXCL_OFF,
      EXCL_DIAGONAL,
      EXCL_REVERSED,
      EXCL_FIVE,
      EXCL_POINT,
      EXCL_RANDOM
   } excl_setup_type;

   // pause after the last result before touching the registers or ending
   localparam int SETTLE_CYCLES = 12;
   localparam int END_GUARD     = 20000;
   localparam int HOLD_CYCLES   = 300;
   localparam int PRINT_LIMIT   = 40;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;

   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   // vertex_x[11:0], vertex_y[23:12]
   logic [plef_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                            req_tlast  = 1'b0;

   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   // long_tail_x, long_tail_y, long_head_x, long_head_y, shorter_count, pad
   logic [plef_pkg::RSP_DATA_W-1:0] rsp_tdata;
   // found
   logic                            rsp_tuser;

   logic                            csr_we    = 1'b0;
   logic [plef_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [plef_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // exclusion registers as the block should hold them (reset value zero)
   logic      excl_on = 1'b0;
   coord_type excl_hx = '0;
   coord_type excl_hy = '0;
   coord_type excl_tx = '0;
   coord_type excl_ty = '0;

   // polygon in progress
   coord_type first_x, first_y, prev_x, prev_y;
   logic      seen_first;
   longint    best_sq;
   coord_type best_tx, best_ty, best_hx, best_hy;
   logic      best_ok;
   int        short_cnt;

   edge_report_type results_due[$];
   int              mismatches     = 0;
   int              send_idle_pct  = 0;
   int              sink_stall_pct = 0;
   int              hold_left      = 0;

   polygon_longest_edge_finder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Running model of the block
   // ------------------------------------------------------------------------

   // exact squared distance between two points
   function automatic longint span_sq(input coord_type ax, ay, bx, by);
      longint dx, dy;
      dx = longint'(ax) - longint'(bx);
      dy = longint'(ay) - longint'(by);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      return dx * dx + dy * dy;
   endfunction

   // drop everything about the current polygon; registers stay
   function automatic void forget_polygon();
      first_x    = '0;
      first_y    = '0;
      prev_x     = '0;
      prev_y     = '0;
      seen_first = 1'b0;
      best_sq    = 0;
      best_tx    = '0;
      best_ty    = '0;
      best_hx    = '0;
      best_hy    = '0;
      best_ok    = 1'b0;
      short_cnt  = 0;
   endfunction

   // fold one edge (tail -> head) into the running maximum and the count
   function automatic void consider_edge(input coord_type tx, ty, hx, hy);
      longint len, excl_len;
      logic   is_short;
      // skip the excluded edge in either direction
      if (excl_on &&
          ((hx == excl_hx && hy == excl_hy && tx == excl_tx && ty == excl_ty) ||
           (hx == excl_tx && hy == excl_ty && tx == excl_hx && ty == excl_hy)))
         return;
      len = span_sq(tx, ty, hx, hy);
      // strict compare: a tie keeps the earlier edge, zero length never wins
      if (len > best_sq) begin
         best_sq = len;
         best_tx = tx;
         best_ty = ty;
         best_hx = hx;
         best_hy = hy;
         best_ok = 1'b1;
      end
      if (excl_on) begin
         // len <= 0.8 * excl, squared and scaled to stay in integers
         excl_len = span_sq(excl_hx, excl_hy, excl_tx, excl_ty);
         is_short = (excl_len != 0) && (25 * len <= 16 * excl_len);
      end else begin
         is_short = 1'b1;
      end
      if (is_short && short_cnt < plef_pkg::COUNT_LIMIT)
         short_cnt++;
   endfunction

   // advance the model by one accepted vertex; queue a result on the last one
   function automatic void follow_vertex(input coord_type x, y, input logic last);
      edge_report_type r;
      if (seen_first) begin
         consider_edge(prev_x, prev_y, x, y);
      end else begin
         first_x    = x;
         first_y    = y;
         seen_first = 1'b1;
      end
      prev_x = x;
      prev_y = y;
      if (last) begin
         // closing edge runs from the last vertex back to the first
         consider_edge(x, y, first_x, first_y);
         r.found  = best_ok;
         r.tail_x = best_ok ? best_tx : '0;
         r.tail_y = best_ok ? best_ty : '0;
         r.head_x = best_ok ? best_hx : '0;
         r.head_y = best_ok ? best_hy : '0;
         r.count  = plef_pkg::COUNT_W'(short_cnt);
         results_due.push_back(r);
         forget_polygon();
      end
   endfunction

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("%0t ns: mismatch: %s", $time, what);
   endtask

   task automatic compare_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   // unpack one result word and hold it against the oldest expectation
   task automatic check_result();
      edge_report_type want;
      if (results_due.size() == 0) begin
         report_mismatch("result word with no polygon pending");
         return;
      end
      want = results_due.pop_front();
      compare_field("found",         rsp_tuser,         want.found);
      compare_field("long_tail_x",   rsp_tdata[11:0],   want.tail_x);
      compare_field("long_tail_y",   rsp_tdata[23:12],  want.tail_y);
      compare_field("long_head_x",   rsp_tdata[35:24],  want.head_x);
      compare_field("long_head_y",   rsp_tdata[47:36],  want.head_y);
      compare_field("shorter_count", rsp_tdata[58:48],  want.count);
      compare_field("pad", rsp_tdata[plef_pkg::RSP_DATA_W-1:59], 0);
   endtask

   // Result side: check every accepted word, then pick tready for the next
   // cycle. A pending hold-off forces tready low and counts down here.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         check_result();
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Offer one vertex, maybe after a random idle gap, and wait for it to be
   // taken. Valid stays high afterwards so back-to-back words need no gap.
   task automatic send_vertex(input coord_type x, y, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {y, x};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      follow_vertex(x, y, last);
   endtask

   // Drop valid, wait for every pending result, then let the pipeline empty.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all five registers, only once the block is idle.
   task automatic apply_config(input logic en, input coord_type hx, hy, tx, ty);
      settle();
      csr_we    <= 1'b1;
      csr_index <= plef_pkg::CSR_EXCL_ENABLE;
      csr_wdata <= plef_pkg::CSR_DATA_W'(en);
      @(posedge clock);
      csr_index <= plef_pkg::CSR_EXCL_HEAD_X;
      csr_wdata <= hx;
      @(posedge clock);
      csr_index <= plef_pkg::CSR_EXCL_HEAD_Y;
      csr_wdata <= hy;
      @(posedge clock);
      csr_index <= plef_pkg::CSR_EXCL_TAIL_X;
      csr_wdata <= tx;
      @(posedge clock);
      csr_index <= plef_pkg::CSR_EXCL_TAIL_Y;
      csr_wdata <= ty;
      @(posedge clock);
      csr_we <= 1'b0;
      excl_on = en;
      excl_hx = hx;
      excl_hy = hy;
      excl_tx = tx;
      excl_ty = ty;
   endtask

   task automatic setup_exclusion(input excl_setup_type kind);
      coord_type hx, hy;
      case (kind)
         EXCL_OFF:      apply_config(1'b0, coord_type'($urandom), coord_type'($urandom),
                                     coord_type'($urandom), coord_type'($urandom));
         EXCL_DIAGONAL: apply_config(1'b1, '0, '0, '1, '1);
         EXCL_REVERSED: apply_config(1'b1, '1, '1, '0, '0);
         // length 5: an edge of 4 is short, anything longer is not
         EXCL_FIVE:     apply_config(1'b1, 103, 204, 100, 200);
         EXCL_POINT:    apply_config(1'b1, 7, 7, 7, 7);
         default: begin
            hx = coord_type'($urandom);
            hy = coord_type'($urandom);
            // half short excluded edges so the ratio test sees both sides
            if ($urandom_range(1))
               apply_config(1'b1, hx, hy, coord_type'(hx + $urandom_range(15)),
                            coord_type'(hy + $urandom_range(15)));
            else
               apply_config(1'b1, hx, hy, coord_type'($urandom), coord_type'($urandom));
         end
      endcase
   endtask

   // Next vertex of a random polygon: full-range points and small steps, with
   // the excluded endpoints, repeats and corners mixed in.
   function automatic void pick_vertex(input coord_type px, py,
                                       output coord_type vx, vy);
      int slot;
      slot = $urandom_range(9);
      case (slot)
         3: begin
            vx = excl_hx;
            vy = excl_hy;
         end
         4: begin
            vx = excl_tx;
            vy = excl_ty;
         end
         5: begin
            vx = px;
            vy = py;
         end
         6, 7, 8: begin
            // small step around the previous vertex; wraps at the edges
            vx = coord_type'(px + $urandom_range(12) - 6);
            vy = coord_type'(py + $urandom_range(12) - 6);
         end
         9: begin
            vx = $urandom_range(1) ? '1 : '0;
            vy = $urandom_range(1) ? '1 : '0;
         end
         default: begin
            vx = coord_type'($urandom);
            vy = coord_type'($urandom);
         end
      endcase
   endfunction

   task automatic run_random_polygons(input int items);
      int        sent, n;
      coord_type px, py, vx, vy;
      sent = 0;
      px   = coord_type'($urandom);
      py   = coord_type'($urandom);
      while (sent < items) begin
         n = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
         for (int i = 0; i < n; i++) begin
            pick_vertex(px, py, vx, vy);
            send_vertex(vx, vy, i == n - 1);
            px = vx;
            py = vy;
         end
         sent += n;
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Field extremes, ties, degenerate polygons and every exclusion case.
   task automatic test_directed_extremes();
      apply_config(1'b0, '0, '0, '0, '0);
      // single vertex: zero-length closing edge, not found but counted
      send_vertex('0, '0, 1'b1);
      send_vertex('1, '1, 1'b1);
      // two vertices: both edges tie, the first one stays
      send_vertex('0, '0, 1'b0);
      send_vertex('1, '1, 1'b1);
      // square: four equal edges
      send_vertex(10, 10, 1'b0);
      send_vertex(20, 10, 1'b0);
      send_vertex(20, 20, 1'b0);
      send_vertex(10, 20, 1'b1);
      // all vertices equal: nothing found, every edge counted
      send_vertex(5, 5, 1'b0);
      send_vertex(5, 5, 1'b0);
      send_vertex(5, 5, 1'b1);

      // excluded edge hit in both directions
      apply_config(1'b1, '0, '0, '1, '1);
      send_vertex('0, '0, 1'b0);
      send_vertex('1, '1, 1'b1);
      // same length as the excluded edge: kept, but not short
      send_vertex('1, '0, 1'b0);
      send_vertex('0, '1, 1'b1);

      // length 5 exclusion: 4 is short, sqrt(17) is not
      apply_config(1'b1, 103, 204, 100, 200);
      send_vertex(0, 0, 1'b0);
      send_vertex(4, 0, 1'b0);
      send_vertex(4, 1, 1'b1);
      send_vertex(100, 200, 1'b0);
      send_vertex(103, 204, 1'b1);

      // zero-length exclusion: nothing counts as short
      apply_config(1'b1, 7, 7, 7, 7);
      send_vertex(7, 7, 1'b0);
      send_vertex(7, 7, 1'b0);
      send_vertex(9, 9, 1'b1);
   endtask

   // Hold the result side off for a long stretch while single-vertex
   // polygons keep coming, so the block fills and drops req_tready.
   task automatic test_backpressure();
      setup_exclusion(EXCL_OFF);
      send_idle_pct  = 0;
      sink_stall_pct = 0;
      hold_left      = HOLD_CYCLES;
      for (int i = 0; i < 40; i++)
         send_vertex(coord_type'($urandom), coord_type'($urandom), 1'b1);
      settle();
   endtask

   // One polygon with more edges than the count can hold.
   task automatic test_count_saturation();
      int n;
      n = plef_pkg::COUNT_LIMIT + 4;
      setup_exclusion(EXCL_OFF);
      for (int i = 0; i < n; i++)
         send_vertex(coord_type'($urandom), coord_type'($urandom), i == n - 1);
      settle();
   endtask

   // Random polygons under each idle mix and a rotation of exclusion setups.
   task automatic test_random_phases();
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               sink_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 63;
               sink_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               sink_stall_pct = 63;
            end
            default: begin
               send_idle_pct  = 14;
               sink_stall_pct = 14;
            end
         endcase
         for (int k = 0; k < 3; k++) begin
            setup_exclusion(excl_setup_type'((phase * 3 + k) % 6));
            run_random_polygons(64);
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------

   initial begin
      int guard;
      forget_polygon();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed_extremes();
      test_backpressure();
      test_count_saturation();
      test_random_phases();

      // drain whatever is still in flight, within a bound
      guard = 0;
      req_tvalid <= 1'b0;
      while (results_due.size() != 0 && guard < END_GUARD) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (results_due.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", results_due.size()));

      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // watchdog: a hung handshake ends the run here
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* files.f */
src/plef_pkg.sv
src/plef_sq_len.sv
src/polygon_longest_edge_finder.sv
verif/polygon_longest_edge_finder_test.sv
